// ===== rtl/bbv_pkg.sv =====
package bbv_pkg;

	localparam int MAX_DEPTH = 255;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_OPEN      = 8'h7B;
	localparam logic [7:0] CH_CLOSE     = 8'h7D;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_LINE,
		MODE_BLOCK,
		MODE_STRING
	} lex_mode_t;

	typedef struct packed {
		lex_mode_t            mode;
		logic                 escape;
		logic                 slash;
		logic                 star;
		logic [DEPTH_W-1:0]   depth;
		logic                 brace_seen;
		logic                 failed;
	} scan_state_t;

	typedef struct packed {
		logic step;
		logic last;
	} scan_ctl_t;

endpackage

// ===== rtl/brace_balance_text_validator.sv =====
// Checks a text, delivered one byte per transaction with the last byte flagged, for balanced
// braces outside line comments, block comments and quoted strings, and gives one verdict
// transaction after the final byte. Bytes are taken at one per cycle: each byte is held in an
// input register and scanned by a single stage of shallow logic, and the verdict sits in an
// output register, so a final byte is only held back while an earlier verdict is still waiting
// to be taken. The verdict is registered from the scan of the final byte. A NUL byte, a
// line break inside a string, an unmatched close brace or nesting beyond the depth limit fails
// the text, as does a text with no brace at all; after each verdict the scanner starts afresh.
module brace_balance_text_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       well_formed
);
	import bbv_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       out_valid_q;
	logic       well_formed_q;
	logic       verdict;
	logic       advance;
	scan_ctl_t  ctl;

	assign in_stall = valid_s1 && final_s1 && out_valid_q && out_stall;
	assign advance  = valid_s1 && !in_stall;

	assign ctl.step = advance;
	assign ctl.last = final_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= text_byte;
			final_s1 <= final_byte;
		end
	end

	bbv_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.text_byte (byte_s1),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			well_formed_q <= verdict;
		end
	end

	assign out_valid   = out_valid_q;
	assign well_formed = well_formed_q;

	a_stall_only_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && final_s1 && out_valid_q)
		else $error("Input held back without a final byte waiting on the output.");

	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && final_s1 |=> out_valid_q)
		else $error("Final byte scanned but no verdict presented.");

	a_result_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && final_s1))
		else $error("Verdict presented without a final byte.");

endmodule

// ===== rtl/bbv_scan.sv =====
module bbv_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  bbv_pkg::scan_ctl_t ctl,
	input  logic [7:0]        text_byte,
	output logic              verdict
);
	import bbv_pkg::*;

	scan_state_t state_q;
	scan_state_t upd;

	always_comb begin
		upd = state_q;
		if (!state_q.failed) begin
			if (text_byte == CH_NUL) begin
				upd.failed = 1'b1;
			end else begin
				case (state_q.mode)
					MODE_LINE: begin
						if (text_byte == CH_LF) begin
							upd.mode = MODE_NORMAL;
						end
					end
					MODE_BLOCK: begin
						if (state_q.star && text_byte == CH_SLASH) begin
							upd.star = 1'b0;
							upd.mode = MODE_NORMAL;
						end else begin
							upd.star = (text_byte == CH_STAR);
						end
					end
					MODE_STRING: begin
						if (text_byte == CH_LF || text_byte == CH_CR) begin
							upd.failed = 1'b1;
						end else if (state_q.escape) begin
							upd.escape = 1'b0;
						end else if (text_byte == CH_BACKSLASH) begin
							upd.escape = 1'b1;
						end else if (text_byte == CH_QUOTE) begin
							upd.mode = MODE_NORMAL;
						end
					end
					default: begin
						upd.slash = 1'b0;
						if (state_q.slash && text_byte == CH_SLASH) begin
							upd.mode = MODE_LINE;
						end else if (state_q.slash && text_byte == CH_STAR) begin
							upd.mode = MODE_BLOCK;
							upd.star = 1'b0;
						end else if (text_byte == CH_SLASH) begin
							upd.slash = 1'b1;
						end else if (text_byte == CH_QUOTE) begin
							upd.mode   = MODE_STRING;
							upd.escape = 1'b0;
						end else if (text_byte == CH_OPEN) begin
							if (state_q.depth == DEPTH_W'(MAX_DEPTH)) begin
								upd.failed = 1'b1;
							end else begin
								upd.depth      = state_q.depth + 1'b1;
								upd.brace_seen = 1'b1;
							end
						end else if (text_byte == CH_CLOSE) begin
							if (state_q.depth == '0) begin
								upd.failed = 1'b1;
							end else begin
								upd.depth = state_q.depth - 1'b1;
							end
						end
					end
				endcase
			end
		end
	end

	assign verdict = !upd.failed && upd.brace_seen && (upd.depth == '0) &&
		(upd.mode != MODE_STRING) && (upd.mode != MODE_BLOCK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				state_q <= '0;
			end else begin
				state_q <= upd;
			end
		end
	end

	a_depth_implies_brace: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.depth != '0 |-> state_q.brace_seen)
		else $error("Open braces counted without a brace recorded.");

	a_star_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.star |-> state_q.mode == MODE_BLOCK)
		else $error("Pending star outside a block comment.");

	a_slash_in_normal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.slash |-> state_q.mode == MODE_NORMAL)
		else $error("Pending slash outside normal text.");

	a_escape_in_string: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.escape |-> state_q.mode == MODE_STRING)
		else $error("Pending escape outside a string.");

endmodule
